// ===== src/ptg_pkg.sv =====
// shared types and constants of the pulse train generator
`default_nettype none

package ptg_pkg;

    localparam int TIME_BITS_DEFAULT = 16;
    localparam logic [7:0] ENDLESS_COUNT = 8'd255;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_START  = 2'd1,
        CMD_STOP   = 2'd2,
        CMD_SWITCH = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t        command;
        logic [15:0] high_time;
        logic [15:0] low_time;
        logic [7:0]  pulse_count;
        logic        switch_level;
    } cmd_word_t;

    typedef struct packed {
        logic pin_level;
        logic level_reported;
        logic pulsing;
    } res_word_t;

endpackage

`default_nettype wire

// ===== src/ptg_if.sv =====
// handshake channels for commands and results
`default_nettype none

interface ptg_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [15:0] high_time;
    logic [15:0] low_time;
    logic [7:0]  pulse_count;
    logic        switch_level;

    modport source (output valid, command, high_time, low_time, pulse_count, switch_level,
                    input ready);
    modport sink (input valid, command, high_time, low_time, pulse_count, switch_level,
                  output ready);
endinterface

interface ptg_res_if;
    logic valid;
    logic ready;
    logic pin_level;
    logic level_reported;
    logic pulsing;

    modport source (output valid, pin_level, level_reported, pulsing, input ready);
    modport sink (input valid, pin_level, level_reported, pulsing, output ready);
endinterface

`default_nettype wire

// ===== src/ptg_in_stage.sv =====
// input register for command words
`default_nettype none

module ptg_in_stage
    import ptg_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    ptg_cmd_if.sink    cmd,
    input  wire logic  take,
    output logic       valid,
    output cmd_word_t  word
);

    logic      valid_reg;
    logic      valid_next;
    cmd_word_t word_reg;
    logic      accept;

    assign cmd.ready = !valid_reg || take;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            word_reg <= '{command:      cmd_t'(cmd.command),
                          high_time:    cmd.high_time,
                          low_time:     cmd.low_time,
                          pulse_count:  cmd.pulse_count,
                          switch_level: cmd.switch_level};
        end
    end

    assign valid = valid_reg;
    assign word  = word_reg;

endmodule

`default_nettype wire

// ===== src/ptg_engine.sv =====
// pulse train state, next-state logic and result register
`default_nettype none

module ptg_engine
    import ptg_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire cmd_word_t  in_word,
    output logic            take,
    ptg_res_if.source       res
);

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_RUN  = 2'd1,
        MODE_HALT = 2'd2
    } mode_t;

    mode_t                mode_reg, mode_next;
    logic [TIME_BITS:0]   pc_reg, pc_next;
    logic [TIME_BITS-1:0] high_reg, high_next;
    logic [TIME_BITS-1:0] low_reg, low_next;
    logic [7:0]           left_reg, left_next;
    logic                 level_reg, level_next;
    logic                 reported;

    logic                 out_valid_reg, out_valid_next;
    res_word_t            out_word_reg;

    logic [TIME_BITS+15:0] high_ext;
    logic [TIME_BITS+15:0] low_ext;
    logic [TIME_BITS:0]    pc_inc;
    logic [TIME_BITS:0]    period;
    logic                  fall;
    logic                  last_pulse;
    logic                  rise;

    assign take = in_valid && (!out_valid_reg || res.ready);

    // keep the low TIME_BITS bits of the 16-bit time fields
    assign high_ext = {{TIME_BITS{1'b0}}, in_word.high_time};
    assign low_ext  = {{TIME_BITS{1'b0}}, in_word.low_time};

    // saturating phase advance
    assign pc_inc = (pc_reg == '1) ? pc_reg : pc_reg + 1'b1;
    assign period = {1'b0, high_reg} + {1'b0, low_reg};

    assign fall       = level_reg && (pc_inc >= {1'b0, high_reg});
    assign last_pulse = fall && (left_reg != ENDLESS_COUNT) && (left_reg <= 8'd1);
    assign rise       = (!level_reg || (fall && !last_pulse)) && (pc_inc >= period);

    always_comb
    begin
        mode_next  = mode_reg;
        pc_next    = pc_reg;
        high_next  = high_reg;
        low_next   = low_reg;
        left_next  = left_reg;
        level_next = level_reg;
        reported   = 1'b0;

        case (mode_reg)
            MODE_IDLE, MODE_RUN:
            begin
                case (in_word.command)
                    CMD_TICK:
                    begin
                        if (mode_reg == MODE_RUN)
                        begin
                            pc_next = pc_inc;
                            if (last_pulse)
                            begin
                                level_next = 1'b0;
                                left_next  = 8'd0;
                                mode_next  = MODE_IDLE;
                                reported   = 1'b1;
                            end
                            else
                            begin
                                if (fall)
                                begin
                                    level_next = 1'b0;
                                    if (left_reg != ENDLESS_COUNT)
                                    begin
                                        left_next = left_reg - 8'd1;
                                    end
                                end
                                if (rise)
                                begin
                                    level_next = 1'b1;
                                    pc_next    = '0;
                                end
                            end
                        end
                    end
                    CMD_START:
                    begin
                        high_next  = high_ext[TIME_BITS-1:0];
                        low_next   = low_ext[TIME_BITS-1:0];
                        left_next  = in_word.pulse_count;
                        pc_next    = '0;
                        level_next = 1'b1;
                        mode_next  = MODE_RUN;
                        reported   = 1'b1;
                    end
                    CMD_STOP:
                    begin
                        level_next = 1'b0;
                        mode_next  = MODE_HALT;
                        reported   = 1'b1;
                    end
                    CMD_SWITCH:
                    begin
                        level_next = in_word.switch_level;
                        mode_next  = MODE_IDLE;
                        reported   = 1'b1;
                    end
                    default:
                    begin
                        mode_next = mode_reg;
                    end
                endcase
            end
            default:
            begin
                // halted until reset
                level_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            pc_reg        <= '0;
            high_reg      <= '0;
            low_reg       <= '0;
            left_reg      <= '0;
            level_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_word_reg  <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                mode_reg     <= mode_next;
                pc_reg       <= pc_next;
                high_reg     <= high_next;
                low_reg      <= low_next;
                left_reg     <= left_next;
                level_reg    <= level_next;
                out_word_reg <= '{pin_level:      level_next,
                                  level_reported: reported,
                                  pulsing:        (mode_next == MODE_RUN)};
            end
        end
    end

    assign res.valid          = out_valid_reg;
    assign res.pin_level      = out_word_reg.pin_level;
    assign res.level_reported = out_word_reg.level_reported;
    assign res.pulsing        = out_word_reg.pulsing;

endmodule

`default_nettype wire

// ===== src/pulse_train_generator_unit.sv =====
// Pulse train generator: every command word (tick, start, stop, direct switch) yields
// exactly one result word with the pin level, a report flag and the running flag.
// A command is held in an input register and its result word in a result register,
// from which it is offered; a new command word is taken every cycle as long as results
// are drained, since each word's state update is one combinational compare-add-count
// step. TIME_BITS sets how many low bits of the high and low times are kept.
`default_nettype none

module pulse_train_generator_unit
    import ptg_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEFAULT
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    ptg_cmd_if.sink   cmd,
    ptg_res_if.source res
);

    logic      take;
    logic      in_valid;
    cmd_word_t in_word;

    ptg_in_stage u_in_stage (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .take  (take),
        .valid (in_valid),
        .word  (in_word)
    );

    ptg_engine #(
        .TIME_BITS (TIME_BITS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_word  (in_word),
        .take     (take),
        .res      (res)
    );

endmodule

`default_nettype wire

// ===== src/ptg_checker.sv =====
// port-level checks on the pulse train generator
`default_nettype none

module ptg_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire logic pin_level,
    input wire logic level_reported,
    input wire logic pulsing
);

    // a stalled result word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable({pin_level, level_reported, pulsing}))
        else $error("result word changed while stalled");

    // a reported word that leaves the train running is a start: pin high
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && pulsing && level_reported |-> pin_level)
        else $error("start reported with pin low");

    // a train only begins with a reported start
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !pulsing |=> !res_valid || !pulsing || level_reported)
        else $error("pulsing began without a reported start");

endmodule

bind pulse_train_generator_unit ptg_checker u_ptg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res.valid),
    .res_ready      (res.ready),
    .pin_level      (res.pin_level),
    .level_reported (res.level_reported),
    .pulsing        (res.pulsing)
);

`default_nettype wire

// ===== tb/sv/tb.sv =====
// self-checking testbench of the pulse train generator unit
`default_nettype none

module tb;
    import ptg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 160;
    localparam int STALL_LIMIT     = 4000;
    localparam int RANDOM_WORDS    = 1740;
    localparam int MAX_REPORTS     = 10;

    typedef enum logic [1:0] {
        PIN_IDLE    = 2'd0,
        PIN_RUNNING = 2'd1,
        PIN_HALTED  = 2'd2
    } pin_mode_t;

    logic clk;
    logic rst_n;

    ptg_cmd_if cmd_ch ();
    ptg_res_if res_ch ();

    pulse_train_generator_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .res   (res_ch)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    cmd_word_t cmd_backlog[$];
    res_word_t pin_expect[$];
    cmd_word_t next_word;

    // own copy of the generator state
    pin_mode_t   mode_q  = PIN_IDLE;
    logic [16:0] phase_q = '0;
    logic [15:0] high_q  = '0;
    logic [15:0] low_q   = '0;
    logic [7:0]  left_q  = '0;
    logic        level_q = 1'b0;

    int fault_count;
    int words_in;
    int words_out;
    int idle_cycles;
    int hold_left;
    bit hold_done;
    int n_start, n_tick, n_switch, n_stop, n_train_end, n_halted;

    function automatic void queue_word(cmd_t c, logic [15:0] h, logic [15:0] l,
                                       logic [7:0] n, logic s);
        cmd_word_t w;
        w.command      = c;
        w.high_time    = h;
        w.low_time     = l;
        w.pulse_count  = n;
        w.switch_level = s;
        cmd_backlog.push_back(w);
    endfunction

    // tick with junk in the unused fields
    function automatic void queue_ticks(int count);
        for (int k = 0; k < count; k++)
            queue_word(CMD_TICK, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
    endfunction

    function automatic logic [15:0] pick_time();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 16'($urandom_range(65535));
        else if (r < 11)
            return 16'hFFFF;
        else
            return 16'($urandom_range(6));
    endfunction

    function automatic logic [7:0] pick_count();
        int r;
        r = $urandom_range(99);
        if (r < 35)
            return 8'($urandom_range(4));
        else if (r < 50)
            return ENDLESS_COUNT;
        else if (r < 60)
            return 8'($urandom_range(255));
        else
            return 8'($urandom_range(8, 1));
    endfunction

    function automatic res_word_t step_pin(cmd_word_t w);
        res_word_t   r;
        logic        rep;
        logic [17:0] period;
        rep = 1'b0;
        if (mode_q != PIN_IDLE && mode_q != PIN_RUNNING) begin
            level_q = 1'b0;
            n_halted++;
        end
        else begin
            case (w.command)
                CMD_TICK:
                begin
                    n_tick++;
                    if (mode_q == PIN_RUNNING) begin
                        if (phase_q != '1)
                            phase_q = phase_q + 17'd1;
                        period = {2'b00, high_q} + {2'b00, low_q};
                        if (level_q && phase_q >= {1'b0, high_q}) begin
                            level_q = 1'b0;
                            if (left_q != ENDLESS_COUNT) begin
                                if (left_q <= 8'd1) begin
                                    // last falling edge ends the train
                                    left_q = '0;
                                    mode_q = PIN_IDLE;
                                    rep    = 1'b1;
                                    n_train_end++;
                                end
                                else
                                    left_q = left_q - 8'd1;
                            end
                        end
                        if (mode_q == PIN_RUNNING && !level_q && {1'b0, phase_q} >= period)
                        begin
                            level_q = 1'b1;
                            phase_q = '0;
                        end
                    end
                end
                CMD_START:
                begin
                    n_start++;
                    high_q  = w.high_time;
                    low_q   = w.low_time;
                    left_q  = w.pulse_count;
                    phase_q = '0;
                    level_q = 1'b1;
                    mode_q  = PIN_RUNNING;
                    rep     = 1'b1;
                end
                CMD_STOP:
                begin
                    n_stop++;
                    level_q = 1'b0;
                    mode_q  = PIN_HALTED;
                    rep     = 1'b1;
                end
                default:
                begin
                    n_switch++;
                    level_q = w.switch_level;
                    mode_q  = PIN_IDLE;
                    rep     = 1'b1;
                end
            endcase
        end
        r.pin_level      = level_q;
        r.level_reported = rep;
        r.pulsing        = (mode_q == PIN_RUNNING);
        return r;
    endfunction

    // idling is switched off for a stretch in the middle of the run
    function automatic bit calm_window();
        return words_in >= 800 && words_in < 1100;
    endfunction

    // command driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cmd_ch.valid        <= 1'b0;
            cmd_ch.command      <= CMD_TICK;
            cmd_ch.high_time    <= '0;
            cmd_ch.low_time     <= '0;
            cmd_ch.pulse_count  <= '0;
            cmd_ch.switch_level <= 1'b0;
        end
        else if (!cmd_ch.valid || cmd_ch.ready) begin
            if (cmd_backlog.size() != 0 && (calm_window() || $urandom_range(99) >= 28)) begin
                next_word = cmd_backlog.pop_front();
                cmd_ch.valid        <= 1'b1;
                cmd_ch.command      <= next_word.command;
                cmd_ch.high_time    <= next_word.high_time;
                cmd_ch.low_time     <= next_word.low_time;
                cmd_ch.pulse_count  <= next_word.pulse_count;
                cmd_ch.switch_level <= next_word.switch_level;
            end
            else
                cmd_ch.valid <= 1'b0;
        end
    end

    // result receiver, with one long hold-off while commands keep coming
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_ch.ready <= 1'b0;
            hold_left    <= 0;
            hold_done    <= 1'b0;
        end
        else if (hold_left > 0) begin
            hold_left    <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (!hold_done && words_in >= 300) begin
            hold_left    <= HOLD_OFF_CYCLES;
            hold_done    <= 1'b1;
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= calm_window() || $urandom_range(99) >= 28;
    end

    // accepted command word: predict its result
    always @(posedge clk)
    begin
        cmd_word_t seen;
        if (rst_n && cmd_ch.valid && cmd_ch.ready) begin
            seen.command      = cmd_t'(cmd_ch.command);
            seen.high_time    = cmd_ch.high_time;
            seen.low_time     = cmd_ch.low_time;
            seen.pulse_count  = cmd_ch.pulse_count;
            seen.switch_level = cmd_ch.switch_level;
            pin_expect.push_back(step_pin(seen));
            words_in++;
        end
    end

    // accepted result word: check against the oldest prediction
    always @(posedge clk)
    begin
        res_word_t got;
        res_word_t want;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.pin_level      = res_ch.pin_level;
            got.level_reported = res_ch.level_reported;
            got.pulsing        = res_ch.pulsing;
            words_out++;
            if (pin_expect.size() == 0) begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("result word %0d arrived with none expected: pin %b rep %b run %b",
                             words_out, got.pin_level, got.level_reported, got.pulsing);
            end
            else begin
                want = pin_expect.pop_front();
                if (got.pin_level !== want.pin_level
                    || got.level_reported !== want.level_reported
                    || got.pulsing !== want.pulsing) begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                        $display("result word %0d: expected pin %b rep %b run %b, got %b %b %b",
                                 words_out, want.pin_level, want.level_reported,
                                 want.pulsing, got.pin_level, got.level_reported,
                                 got.pulsing);
                end
            end
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        int r;
        rst_n = 1'b0;

        // directed words
        queue_ticks(1);                                    // tick while idle
        queue_word(CMD_SWITCH, 16'h0000, 16'h0000, 8'h00, 1'b1);
        queue_ticks(1);
        queue_word(CMD_SWITCH, 16'hFFFF, 16'hFFFF, 8'hFF, 1'b0);
        queue_word(CMD_START, 16'd0, 16'd0, 8'd0, 1'b0);   // zero count and zero times
        queue_ticks(2);
        queue_word(CMD_START, 16'd0, 16'd1, 8'd2, 1'b1);   // zero high time
        queue_ticks(4);
        queue_word(CMD_START, 16'd2, 16'd0, 8'd3, 1'b0);   // zero low time
        queue_ticks(7);
        queue_word(CMD_START, 16'hFFFF, 16'hFFFF, ENDLESS_COUNT, 1'b1);
        queue_ticks(1);
        queue_word(CMD_START, 16'd1, 16'd1, ENDLESS_COUNT, 1'b0);  // restart while running
        queue_ticks(4);
        queue_word(CMD_SWITCH, 16'd0, 16'd0, 8'd0, 1'b1);  // switch ends the train

        // random trains with noise in between
        while (cmd_backlog.size() < RANDOM_WORDS) begin
            r = $urandom_range(99);
            if (r < 72) begin
                queue_word(CMD_START, pick_time(), pick_time(), pick_count(), 1'($urandom));
                queue_ticks($urandom_range(99) < 10 ? $urandom_range(90, 40)
                                                     : $urandom_range(30, 2));
            end
            else if (r < 86) begin
                queue_word(CMD_SWITCH, 16'($urandom), 16'($urandom), 8'($urandom),
                           1'($urandom));
                queue_ticks($urandom_range(4));
            end
            else begin
                queue_word(CMD_START, 16'($urandom), 16'($urandom), 8'($urandom),
                           1'($urandom));
                queue_ticks($urandom_range(6));
            end
        end

        // stop halts the block for the rest of the run
        queue_word(CMD_STOP, 16'($urandom), 16'($urandom), 8'($urandom), 1'($urandom));
        queue_ticks(2);
        queue_word(CMD_START, 16'd1, 16'd1, 8'd3, 1'b1);
        queue_ticks(2);
        queue_word(CMD_SWITCH, 16'd0, 16'd0, 8'd0, 1'b1);
        queue_word(CMD_STOP, 16'd0, 16'd0, 8'd0, 1'b0);

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (cmd_backlog.size() != 0 || cmd_ch.valid || pin_expect.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (pin_expect.size() != 0)
            fault_count++;
        $display("%0d command words in, %0d result words checked, %0d faults", words_in,
                 words_out, fault_count);
        $display("starts %0d, ticks %0d, switches %0d, stops %0d, trains run out %0d, halted %0d",
                 n_start, n_tick, n_switch, n_stop, n_train_end, n_halted);
        if (fault_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
